@@ design/plt_pkg.sv @@
// Shared constants, register codes and types of the Phong point-light shader.
// Used by plt_dir, plt_lgt and the top level phong_point_light_shader.
`default_nettype none

package plt_pkg;

  localparam int COLOR_FRAC_BITS = 14;
  localparam int EXPONENT_BITS   = 8;
  localparam int VEC_FRAC        = 14;
  localparam int VEC_ONE         = 1 << VEC_FRAC;

  localparam int CH_W   = 16;
  localparam int RGB_W  = 3 * CH_W;
  localparam int POS_W  = 32;
  localparam int VEC_W  = 16;
  localparam int CFG_W  = 48;
  localparam int SHIN_W = 8;
  localparam int IDX_W  = 3;

  // color datapath widths
  localparam int EFF_W  = 2 * CH_W - COLOR_FRAC_BITS;
  localparam int AMB_W  = EFF_W + CH_W - COLOR_FRAC_BITS;
  localparam int STM_W  = EFF_W;
  localparam int NDL_W  = 17;
  localparam int PW_W   = VEC_FRAC + 1;
  localparam int DFT_W  = AMB_W + NDL_W - VEC_FRAC;
  localparam int SPT_W  = STM_W + PW_W - VEC_FRAC;
  localparam int SUM_W  = DFT_W + 2;
  localparam int CAP    = ((1 << COLOR_FRAC_BITS) < 65535) ? (1 << COLOR_FRAC_BITS) : 65535;

  // light direction pipe
  localparam int DIF_W      = POS_W + 1;
  localparam int PSH_W      = $clog2(DIF_W);
  localparam int NRM_MSB    = 29;
  localparam int NRM_W      = NRM_MSB + 1;
  localparam int SQS_W      = 2 * NRM_W + 2;
  localparam int SQ_STAGES  = SQS_W / 2;
  localparam int LEN_W      = SQ_STAGES;
  localparam int DIV_STAGES = VEC_FRAC + 1;
  localparam int DVR_W      = NRM_W + VEC_FRAC;
  localparam int DIR_LAT    = 5 + SQ_STAGES + DIV_STAGES + 1;

  // lighting pipe
  localparam int LGT_LAT  = 7 + EXPONENT_BITS;
  localparam int SIDE_END = DIR_LAT + LGT_LAT;
  localparam int TOT_LAT  = SIDE_END + 2;

  localparam logic [RGB_W-1:0]  RGB_RST  = 48'h4000_4000_4000;
  localparam logic [CH_W-1:0]   GAIN_RST = 16'd14746;
  localparam logic [SHIN_W-1:0] SHIN_RST = 8'd200;

  typedef enum logic [IDX_W-1:0] {
    REG_LIGHT_X   = 3'd0,
    REG_LIGHT_Y   = 3'd1,
    REG_LIGHT_Z   = 3'd2,
    REG_LIGHT_RGB = 3'd3,
    REG_AMB_RGB   = 3'd4,
    REG_DIF_GAIN  = 3'd5,
    REG_SPC_GAIN  = 3'd6,
    REG_SHININESS = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic             lit;
    logic             spec;
    logic [NDL_W-1:0] ndl;
    logic [PW_W-1:0]  pw;
  } lgt_res_t;

endpackage

`default_nettype wire

@@ design/plt_dir.sv @@
// Unit vector from hit point to light: difference, scaling, pipelined square
// root and pipelined three-lane divide. Depends on plt_pkg.
`default_nettype none

module plt_dir (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [2:0][plt_pkg::POS_W-1:0]      light_i,
  input  logic [2:0][plt_pkg::POS_W-1:0]      point_i,
  output logic [2:0][plt_pkg::VEC_W-1:0]      u_o
);
  import plt_pkg::*;

  localparam int CAR_N = 3 + SQ_STAGES;

  typedef struct packed {
    logic [2:0][NRM_W-1:0] mag;
    logic [2:0]            neg;
    logic                  zero;
  } car_t;

  // stage 1: difference and magnitude
  logic [2:0][DIF_W-1:0] mag1_d, mag1_q;
  logic [2:0]            neg1_d, neg1_q;
  // stage 2: largest magnitude and its top bit
  logic [2:0][DIF_W-1:0] mag2_q;
  logic [2:0]            neg2_q;
  logic [PSH_W-1:0]      msb2_d, msb2_q;
  logic                  zero2_d, zero2_q;
  // stage 3 onward: scaled magnitudes ride along the square root
  car_t                  car_d;
  car_t                  car_q [CAR_N];
  logic [2:0][2*NRM_W-1:0] sq_d, sq_q;
  logic [SQS_W-1:0]      sum_d, sum_q;
  logic [LEN_W-1:0]      rt_d [SQ_STAGES];
  logic [LEN_W-1:0]      rt_q [SQ_STAGES];
  logic [SQS_W-1:0]      rm_d [SQ_STAGES];
  logic [SQS_W-1:0]      rm_q [SQ_STAGES];
  // divide stages
  logic [2:0][DVR_W-1:0] dr_d [DIV_STAGES];
  logic [2:0][DVR_W-1:0] dr_q [DIV_STAGES];
  logic [2:0][PW_W-1:0]  dq_d [DIV_STAGES];
  logic [2:0][PW_W-1:0]  dq_q [DIV_STAGES];
  logic [LEN_W-1:0]      dl_q [DIV_STAGES];
  logic [2:0]            dn_q [DIV_STAGES];
  logic                  dz_q [DIV_STAGES];
  logic [2:0][VEC_W-1:0] u_d, u_q;

  always_comb begin
    logic signed [DIF_W-1:0] dif;
    for (int i = 0; i < 3; i++) begin
      dif = $signed({light_i[i][POS_W-1], light_i[i]})
          - $signed({point_i[i][POS_W-1], point_i[i]});
      neg1_d[i] = dif[DIF_W-1];
      mag1_d[i] = dif[DIF_W-1] ? DIF_W'(-dif) : DIF_W'(dif);
    end
  end

  always_comb begin
    logic [DIF_W-1:0] m;
    m = mag1_q[0];
    if (mag1_q[1] > m) m = mag1_q[1];
    if (mag1_q[2] > m) m = mag1_q[2];
    msb2_d = '0;
    for (int b = 0; b < DIF_W; b++) begin
      if (m[b]) msb2_d = PSH_W'(b);
    end
    zero2_d = (m == '0);
  end

  // scale so the largest magnitude sits in [2^29, 2^30)
  always_comb begin
    logic [DIF_W-1:0] sh;
    car_d.neg  = neg2_q;
    car_d.zero = zero2_q;
    for (int i = 0; i < 3; i++) begin
      if (msb2_q > PSH_W'(NRM_MSB)) begin
        sh = mag2_q[i] >> (msb2_q - PSH_W'(NRM_MSB));
      end else begin
        sh = mag2_q[i] << (PSH_W'(NRM_MSB) - msb2_q);
      end
      car_d.mag[i] = sh[NRM_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = car_q[0].mag[i] * car_q[0].mag[i];
    end
    sum_d = SQS_W'(sq_q[0]) + SQS_W'(sq_q[1]) + SQS_W'(sq_q[2]);
  end

  // floor square root, one result bit per stage
  always_comb begin
    logic [LEN_W-1:0] rt_in;
    logic [SQS_W-1:0] rm_in;
    logic [63:0]      stp;
    for (int k = 0; k < SQ_STAGES; k++) begin
      rt_in = (k == 0) ? '0 : rt_q[(k == 0) ? 0 : k-1];
      rm_in = (k == 0) ? sum_q : rm_q[(k == 0) ? 0 : k-1];
      stp   = (64'(rt_in) << (SQ_STAGES - k)) + (64'd1 << (2 * (SQ_STAGES - 1 - k)));
      if (64'(rm_in) >= stp) begin
        rm_d[k] = rm_in - SQS_W'(stp);
        rt_d[k] = rt_in | (LEN_W'(1) << (SQ_STAGES - 1 - k));
      end else begin
        rm_d[k] = rm_in;
        rt_d[k] = rt_in;
      end
    end
  end

  // restoring divide of (mag << 14) by length, one quotient bit per stage
  always_comb begin
    logic [DVR_W-1:0] r_in;
    logic [PW_W-1:0]  q_in;
    logic [LEN_W-1:0] l_in;
    logic [63:0]      dv;
    for (int k = 0; k < DIV_STAGES; k++) begin
      l_in = (k == 0) ? rt_q[SQ_STAGES-1] : dl_q[(k == 0) ? 0 : k-1];
      dv   = 64'(l_in) << (DIV_STAGES - 1 - k);
      for (int i = 0; i < 3; i++) begin
        r_in = (k == 0) ? {car_q[CAR_N-1].mag[i], VEC_FRAC'(0)}
                        : dr_q[(k == 0) ? 0 : k-1][i];
        q_in = (k == 0) ? '0 : dq_q[(k == 0) ? 0 : k-1][i];
        if (64'(r_in) >= dv) begin
          dr_d[k][i] = r_in - DVR_W'(dv);
          dq_d[k][i] = q_in | (PW_W'(1) << (DIV_STAGES - 1 - k));
        end else begin
          dr_d[k][i] = r_in;
          dq_d[k][i] = q_in;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dz_q[DIV_STAGES-1]) begin
        u_d[i] = '0;
      end else if (dn_q[DIV_STAGES-1][i]) begin
        u_d[i] = VEC_W'(-$signed({1'b0, dq_q[DIV_STAGES-1][i]}));
      end else begin
        u_d[i] = VEC_W'({1'b0, dq_q[DIV_STAGES-1][i]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag1_d;
      neg1_q  <= neg1_d;
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      msb2_q  <= msb2_d;
      zero2_q <= zero2_d;
      car_q[0] <= car_d;
      for (int k = 1; k < CAR_N; k++) car_q[k] <= car_q[k-1];
      sq_q  <= sq_d;
      sum_q <= sum_d;
      for (int k = 0; k < SQ_STAGES; k++) begin
        rt_q[k] <= rt_d[k];
        rm_q[k] <= rm_d[k];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
        dr_q[k] <= dr_d[k];
        dq_q[k] <= dq_d[k];
      end
      dl_q[0] <= rt_q[SQ_STAGES-1];
      dn_q[0] <= car_q[CAR_N-1].neg;
      dz_q[0] <= car_q[CAR_N-1].zero;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dl_q[k] <= dl_q[k-1];
        dn_q[k] <= dn_q[k-1];
        dz_q[k] <= dz_q[k-1];
      end
      u_q <= u_d;
    end
  end

  assign u_o = u_q;

endmodule

`default_nettype wire

@@ design/plt_lgt.sv @@
// Lighting terms: N.L, reflected vector, R.E and the specular power, one
// square-and-multiply step per stage. Depends on plt_pkg.
`default_nettype none

module plt_lgt (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [2:0][plt_pkg::VEC_W-1:0]      u_i,
  input  logic [2:0][plt_pkg::VEC_W-1:0]      n_i,
  input  logic [2:0][plt_pkg::VEC_W-1:0]      e_i,
  input  logic [plt_pkg::SHIN_W-1:0]          shin_i,
  output plt_pkg::lgt_res_t                   res_o
);
  import plt_pkg::*;

  localparam int PRD_W = 2 * VEC_W;
  localparam int T_W   = VEC_W + PRD_W;
  localparam int W_W   = T_W + 2;
  localparam int R_W   = W_W - VEC_FRAC;
  localparam int RE_W  = R_W + VEC_W;
  localparam int RD_W  = RE_W + 2;

  logic signed [PRD_W-1:0] p_d [3];
  logic signed [PRD_W-1:0] p_q [3];
  logic [2:0][VEC_W-1:0]   n1_q, u1_q, e1_q, n2_q, u2_q, e2_q, u3_q, e3_q, e4_q;
  logic signed [PRD_W-1:0] ndl_d, ndl2_q, ndl3_q, ndl4_q, ndl5_q, ndl6_q;
  logic signed [T_W-1:0]   t_d [3];
  logic signed [T_W-1:0]   t_q [3];
  logic signed [R_W-1:0]   r_d [3];
  logic signed [R_W-1:0]   r_q [3];
  logic signed [RE_W-1:0]  q_d [3];
  logic signed [RE_W-1:0]  q_q [3];
  logic signed [RD_W-1:0]  rde_d, rde_q;
  lgt_res_t                   s7_d;
  logic [PW_W-1:0]            b7_d;
  logic [EXPONENT_BITS-1:0]   k7_d;
  lgt_res_t                   ps_d [EXPONENT_BITS+1];
  lgt_res_t                   ps_q [EXPONENT_BITS+1];
  logic [PW_W-1:0]            b_d  [EXPONENT_BITS+1];
  logic [PW_W-1:0]            b_q  [EXPONENT_BITS+1];
  logic [EXPONENT_BITS-1:0]   k_q  [EXPONENT_BITS+1];

  always_comb begin
    logic signed [W_W-1:0] w;
    for (int i = 0; i < 3; i++) begin
      p_d[i] = $signed(n_i[i]) * $signed(u_i[i]);
      t_d[i] = $signed(n2_q[i]) * ndl2_q;
      // R = floor((2*n*ndl - u*2^14) / 2^14)
      w = ($signed({{2{t_q[i][T_W-1]}}, t_q[i]}) <<< 1)
        - ($signed({{(W_W-VEC_W){u3_q[i][VEC_W-1]}}, u3_q[i]}) <<< VEC_FRAC);
      r_d[i] = w[W_W-1:VEC_FRAC];
      q_d[i] = r_q[i] * $signed(e4_q[i]);
    end
    ndl_d = p_q[0] + p_q[1] + p_q[2];
    rde_d = $signed({{2{q_q[0][RE_W-1]}}, q_q[0]})
          + $signed({{2{q_q[1][RE_W-1]}}, q_q[1]})
          + $signed({{2{q_q[2][RE_W-1]}}, q_q[2]});
  end

  always_comb begin
    logic signed [RD_W-1:0] rsh;
    rsh       = rde_q >>> VEC_FRAC;
    s7_d.lit  = !ndl6_q[PRD_W-1];
    s7_d.ndl  = ndl6_q[VEC_FRAC +: NDL_W];
    s7_d.spec = !ndl6_q[PRD_W-1] && !rde_q[RD_W-1] && (rde_q != '0);
    s7_d.pw   = PW_W'(VEC_ONE);
    b7_d      = (rsh > $signed(RD_W'(VEC_ONE))) ? PW_W'(VEC_ONE) : rsh[PW_W-1:0];
    k7_d      = EXPONENT_BITS'(shin_i);
  end

  // square and multiply, exponent bit k-1 in stage k
  always_comb begin
    logic [2*PW_W-1:0] pp;
    logic [2*PW_W-1:0] bb;
    ps_d[0] = s7_d;
    b_d[0]  = b7_d;
    for (int k = 1; k <= EXPONENT_BITS; k++) begin
      pp = ps_q[k-1].pw * b_q[k-1];
      bb = b_q[k-1] * b_q[k-1];
      ps_d[k] = ps_q[k-1];
      if (k_q[k-1][k-1]) ps_d[k].pw = pp[VEC_FRAC +: PW_W];
      b_d[k] = bb[VEC_FRAC +: PW_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= p_d[i];
        t_q[i] <= t_d[i];
        r_q[i] <= r_d[i];
        q_q[i] <= q_d[i];
      end
      n1_q <= n_i;   u1_q <= u_i;   e1_q <= e_i;
      n2_q <= n1_q;  u2_q <= u1_q;  e2_q <= e1_q;
      u3_q <= u2_q;  e3_q <= e2_q;  e4_q <= e3_q;
      ndl2_q <= ndl_d;
      ndl3_q <= ndl2_q;
      ndl4_q <= ndl3_q;
      ndl5_q <= ndl4_q;
      ndl6_q <= ndl5_q;
      rde_q  <= rde_d;
      for (int k = 0; k <= EXPONENT_BITS; k++) begin
        ps_q[k] <= ps_d[k];
        b_q[k]  <= b_d[k];
      end
      k_q[0] <= k7_d;
      for (int k = 1; k <= EXPONENT_BITS; k++) k_q[k] <= k_q[k-1];
    end
  end

  assign res_o = ps_q[EXPONENT_BITS];

endmodule

`default_nettype wire

@@ design/phong_point_light_shader.sv @@
// Top level of the Phong point-light shader: config registers, color terms,
// pipeline control and output register. Depends on plt_pkg, plt_dir, plt_lgt.
//
//  channel  dir  handshake                 payload
//  s_axis   in   tvalid/tready             tdata: hit point, normal, eye, base; tuser: shadow
//  m_axis   out  tvalid/tready             tdata: shaded r, g, b
//  cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item per cycle while the output is not held; the pipe depth is set mostly by
// the 31-stage square root and the 15-stage divide for the light vector.
// All stages advance together: a held output stalls the whole pipe and the
// input, and nothing is dropped or repeated. Reset clears the valid bits and
// loads the register defaults.
`default_nettype none

module phong_point_light_shader (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // point_x, point_y, point_z, normal_x/y/z, eye_x/y/z, base_rgb
  input  logic [239:0]                 s_axis_tdata_i,
  // shadow flag
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // out_r, out_g, out_b
  output logic [47:0]                  m_axis_tdata_o,
  input  logic                         cfg_we_i,
  input  logic [plt_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [plt_pkg::CFG_W-1:0]    cfg_data_i
);
  import plt_pkg::*;

  typedef struct packed {
    logic [2:0][EFF_W-1:0] eff;
    logic [2:0][STM_W-1:0] stm;
    logic                  sh;
    logic [2:0][VEC_W-1:0] n;
    logic [2:0][VEC_W-1:0] e;
  } pre_t;

  typedef struct packed {
    logic [2:0][AMB_W-1:0] amb;
    logic [2:0][AMB_W-1:0] dtm;
    logic [2:0][STM_W-1:0] stm;
    logic                  sh;
    logic [2:0][VEC_W-1:0] n;
    logic [2:0][VEC_W-1:0] e;
  } side_t;

  logic [2:0][POS_W-1:0] light_q, point;
  logic [RGB_W-1:0]      lrgb_q, argb_q, base;
  logic [CH_W-1:0]       dgain_q, sgain_q;
  logic [SHIN_W-1:0]     shin_q;

  logic                  pipe_en;
  logic [TOT_LAT:1]      vld_q;
  pre_t                  pre_d, pre_q;
  side_t                 side_d;
  side_t                 side_q [2:SIDE_END];
  logic [2:0][VEC_W-1:0] n_in, e_in, u;
  lgt_res_t              lres;
  logic [2:0][DFT_W-1:0] dft_d, dft_q;
  logic [2:0][SPT_W-1:0] spt_d, spt_q;
  logic [2:0][AMB_W-1:0] amb_q;
  logic                  sh_f_q, out_sh_q;
  logic [2:0][CH_W-1:0]  out_d, out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q <= '0;
      lrgb_q  <= RGB_RST;
      argb_q  <= RGB_RST;
      dgain_q <= GAIN_RST;
      sgain_q <= GAIN_RST;
      shin_q  <= SHIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LIGHT_X:   light_q[0] <= cfg_data_i[POS_W-1:0];
        REG_LIGHT_Y:   light_q[1] <= cfg_data_i[POS_W-1:0];
        REG_LIGHT_Z:   light_q[2] <= cfg_data_i[POS_W-1:0];
        REG_LIGHT_RGB: lrgb_q     <= cfg_data_i[RGB_W-1:0];
        REG_AMB_RGB:   argb_q     <= cfg_data_i[RGB_W-1:0];
        REG_DIF_GAIN:  dgain_q    <= cfg_data_i[CH_W-1:0];
        REG_SPC_GAIN:  sgain_q    <= cfg_data_i[CH_W-1:0];
        REG_SHININESS: shin_q     <= cfg_data_i[SHIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pipe_en         = !vld_q[TOT_LAT] || m_axis_tready_i;
  assign s_axis_tready_o = pipe_en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      point[i] = s_axis_tdata_i[POS_W*i +: POS_W];
      n_in[i]  = s_axis_tdata_i[3*POS_W + VEC_W*i +: VEC_W];
      e_in[i]  = s_axis_tdata_i[3*POS_W + 3*VEC_W + VEC_W*i +: VEC_W];
    end
    base = s_axis_tdata_i[3*POS_W + 6*VEC_W +: RGB_W];
  end

  // color terms: effective color and specular scale, then ambient and diffuse scale
  always_comb begin
    logic [2*CH_W-1:0]      pe, ps;
    logic [EFF_W+CH_W-1:0]  pa, pd;
    pre_d.sh = s_axis_tuser_i;
    pre_d.n  = n_in;
    pre_d.e  = e_in;
    side_d.sh = pre_q.sh;
    side_d.n  = pre_q.n;
    side_d.e  = pre_q.e;
    side_d.stm = pre_q.stm;
    for (int i = 0; i < 3; i++) begin
      pe = base[CH_W*i +: CH_W] * lrgb_q[CH_W*i +: CH_W];
      ps = lrgb_q[CH_W*i +: CH_W] * sgain_q;
      pre_d.eff[i] = pe[COLOR_FRAC_BITS +: EFF_W];
      pre_d.stm[i] = ps[COLOR_FRAC_BITS +: STM_W];
      pa = pre_q.eff[i] * argb_q[CH_W*i +: CH_W];
      pd = pre_q.eff[i] * dgain_q;
      side_d.amb[i] = pa[COLOR_FRAC_BITS +: AMB_W];
      side_d.dtm[i] = pd[COLOR_FRAC_BITS +: AMB_W];
    end
  end

  plt_dir u_dir (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .light_i (light_q),
    .point_i (point),
    .u_o     (u)
  );

  plt_lgt u_lgt (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .u_i    (u),
    .n_i    (side_q[DIR_LAT].n),
    .e_i    (side_q[DIR_LAT].e),
    .shin_i (shin_q),
    .res_o  (lres)
  );

  always_comb begin
    logic [AMB_W+NDL_W-1:0] dp;
    logic [STM_W+PW_W-1:0]  sp;
    logic [SUM_W-1:0]       sum;
    for (int i = 0; i < 3; i++) begin
      dp = side_q[SIDE_END].dtm[i] * lres.ndl;
      sp = side_q[SIDE_END].stm[i] * lres.pw;
      dft_d[i] = lres.lit  ? dp[VEC_FRAC +: DFT_W] : '0;
      spt_d[i] = lres.spec ? sp[VEC_FRAC +: SPT_W] : '0;
      sum = SUM_W'(amb_q[i]) + SUM_W'(dft_q[i]) + SUM_W'(spt_q[i]);
      if (sh_f_q) begin
        out_d[i] = (64'(amb_q[i]) > 64'hFFFF) ? 16'hFFFF : CH_W'(amb_q[i]);
      end else begin
        out_d[i] = (64'(sum) > 64'(CAP)) ? CH_W'(CAP) : CH_W'(sum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[TOT_LAT-1:1], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pre_q     <= pre_d;
      side_q[2] <= side_d;
      for (int k = 3; k <= SIDE_END; k++) side_q[k] <= side_q[k-1];
      dft_q    <= dft_d;
      spt_q    <= spt_d;
      amb_q    <= side_q[SIDE_END].amb;
      sh_f_q   <= side_q[SIDE_END].sh;
      out_q    <= out_d;
      out_sh_q <= sh_f_q;
    end
  end

  assign m_axis_tvalid_o = vld_q[TOT_LAT];
  assign m_axis_tdata_o  = {out_q[2], out_q[1], out_q[0]};

`ifndef SYNTHESIS
  a_lit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !out_sh_q |-> (out_q[0] <= CH_W'(CAP)) &&
      (out_q[1] <= CH_W'(CAP)) && (out_q[2] <= CH_W'(CAP)))
    else $error("lit output above 1.0");
  a_spec_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SIDE_END] && lres.spec |-> lres.lit)
    else $error("specular term on an unlit item");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[1])
    else $error("accepted item lost at pipe entry");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(vld_q))
    else $error("pipe moved during stall");
`endif

endmodule

`default_nettype wire
